@@ rtl/bmpd_pkg.sv @@
// Shared types and constants of the BMP pixel array decoder.
package bmpd_pkg;

  // Largest image side in pixels; row and column counts fit in 12 bits.
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CountW   = 12;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  // Register map, by word index
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PIXEL_MODE   = 2'd2;

  // Pixel modes (code 3 decodes as gray)
  localparam logic [1:0] MODE_BGR24   = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_GRAY    = 2'd2;

  // Input operations
  localparam logic OP_PALETTE_WRITE = 1'b0;
  localparam logic OP_PIXEL_BYTE    = 1'b1;

  // Clamped image geometry and mode
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [1:0]      mode;
  } bmpd_cfg_t;

  // Pixel decoded from the current byte, before the palette lookup
  typedef struct packed {
    logic              emit;
    logic              from_palette;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [CountW-1:0] row;
    logic [CountW-1:0] column;
    logic              last;
  } bmpd_pix_t;

endpackage

@@ rtl/bmpd_cfg.sv @@
// APB register file: image width, image height and pixel mode.
module bmpd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bmpd_pkg::AddrW-1:0]       paddr,
  input  logic [bmpd_pkg::DataW-1:0]       pwdata,
  output logic [bmpd_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  output bmpd_pkg::bmpd_cfg_t              cfg
);

  logic [bmpd_pkg::DimW-1:0] image_width;
  logic [bmpd_pkg::DimW-1:0] image_height;
  logic [1:0]                pixel_mode;
  logic                      wr_en;
  logic [1:0]                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bmpd_pkg::DimW'(1);
      image_height <= bmpd_pkg::DimW'(1);
      pixel_mode   <= bmpd_pkg::MODE_BGR24;
    end else if (wr_en) begin
      case (reg_sel)
        bmpd_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[bmpd_pkg::DimW-1:0];
        bmpd_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[bmpd_pkg::DimW-1:0];
        bmpd_pkg::REG_PIXEL_MODE:   pixel_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bmpd_pkg::REG_IMAGE_WIDTH:
        prdata = bmpd_pkg::DataW'(image_width);
      bmpd_pkg::REG_IMAGE_HEIGHT:
        prdata = bmpd_pkg::DataW'(image_height);
      bmpd_pkg::REG_PIXEL_MODE:
        prdata = bmpd_pkg::DataW'(pixel_mode);
      default:
        prdata = '0;
    endcase
  end

  // zero counts as one, oversize as the largest side
  always_comb begin
    if (image_width == '0)
      cfg.width = bmpd_pkg::DimW'(1);
    else if (image_width > bmpd_pkg::DimW'(bmpd_pkg::MaxDim))
      cfg.width = bmpd_pkg::DimW'(bmpd_pkg::MaxDim);
    else
      cfg.width = image_width;

    if (image_height == '0)
      cfg.height = bmpd_pkg::DimW'(1);
    else if (image_height > bmpd_pkg::DimW'(bmpd_pkg::MaxDim))
      cfg.height = bmpd_pkg::DimW'(bmpd_pkg::MaxDim);
    else
      cfg.height = image_height;

    cfg.mode = pixel_mode;
  end

endmodule

@@ rtl/bmpd_seq.sv @@
// Byte sequencer: BGR gathering, row padding and row/column counters.
module bmpd_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       operation,
  input  logic [7:0]                 data_byte,
  input  bmpd_pkg::bmpd_cfg_t        cfg,
  output bmpd_pkg::bmpd_pix_t        pix
);

  logic [1:0]                  byte_phase, byte_phase_next;
  logic [7:0]                  held_blue, held_blue_next;
  logic [7:0]                  held_green, held_green_next;
  logic [bmpd_pkg::CountW-1:0] column_count, column_count_next;
  logic [bmpd_pkg::CountW-1:0] file_row_count, file_row_count_next;
  logic [1:0]                  pad_bytes_left, pad_bytes_left_next;

  logic                        row_end;
  logic                        last;
  logic [bmpd_pkg::DimW-1:0]   col_inc;
  logic [bmpd_pkg::DimW-1:0]   row_inc;
  logic [bmpd_pkg::DimW-1:0]   top_row;
  logic [1:0]                  row_bytes_lo;
  logic [1:0]                  pad_new;

  assign col_inc = {1'b0, column_count} + bmpd_pkg::DimW'(1);
  assign row_inc = {1'b0, file_row_count} + bmpd_pkg::DimW'(1);
  assign row_end = (col_inc >= cfg.width);
  assign last    = row_end && (row_inc >= cfg.height);
  assign top_row = ({1'b0, file_row_count} >= cfg.height) ? '0
                 : (cfg.height - row_inc);

  // bytes of a row modulo four, then padding up to the next multiple of four
  assign row_bytes_lo = (cfg.mode == bmpd_pkg::MODE_BGR24)
                      ? 2'(cfg.width[1:0] * 2'd3) : cfg.width[1:0];
  assign pad_new      = 2'(2'd0 - row_bytes_lo);

  always_comb begin
    byte_phase_next     = byte_phase;
    held_blue_next      = held_blue;
    held_green_next     = held_green;
    column_count_next   = column_count;
    file_row_count_next = file_row_count;
    pad_bytes_left_next = pad_bytes_left;

    pix.emit         = 1'b0;
    pix.from_palette = 1'b0;
    pix.red          = data_byte;
    pix.green        = data_byte;
    pix.blue         = data_byte;
    pix.row          = top_row[bmpd_pkg::CountW-1:0];
    pix.column       = column_count;
    pix.last         = last;

    if (operation == bmpd_pkg::OP_PIXEL_BYTE) begin
      if (pad_bytes_left != 2'd0) begin
        pad_bytes_left_next = pad_bytes_left - 2'd1;
      end else if (cfg.mode == bmpd_pkg::MODE_BGR24) begin
        case (byte_phase)
          2'd0: begin
            held_blue_next  = data_byte;
            byte_phase_next = 2'd1;
          end
          2'd1: begin
            held_green_next = data_byte;
            byte_phase_next = 2'd2;
          end
          default: begin
            byte_phase_next = 2'd0;
            pix.emit        = 1'b1;
            pix.green       = held_green;
            pix.blue        = held_blue;
          end
        endcase
      end else begin
        byte_phase_next  = 2'd0;
        pix.emit         = 1'b1;
        pix.from_palette = (cfg.mode == bmpd_pkg::MODE_PALETTE);
      end
    end

    if (pix.emit) begin
      if (row_end) begin
        pad_bytes_left_next = pad_new;
        column_count_next   = '0;
        file_row_count_next = last ? '0 : row_inc[bmpd_pkg::CountW-1:0];
      end else begin
        column_count_next   = col_inc[bmpd_pkg::CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= '0;
      held_blue      <= '0;
      held_green     <= '0;
      column_count   <= '0;
      file_row_count <= '0;
      pad_bytes_left <= '0;
    end else if (advance) begin
      byte_phase     <= byte_phase_next;
      held_blue      <= held_blue_next;
      held_green     <= held_green_next;
      column_count   <= column_count_next;
      file_row_count <= file_row_count_next;
      pad_bytes_left <= pad_bytes_left_next;
    end
  end

endmodule

@@ rtl/bmpd_palette.sv @@
// Palette store: one write port, one registered read port.
module bmpd_palette #(
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [23:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [23:0]              rd_data
);

  logic [23:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en)
      rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/bmp_pixel_array_decoder_core.sv @@
// Top level of the BMP pixel array decoder.
//
// Takes the pixel array of a bottom-up BMP one byte per transfer, mixed with
// palette-write transfers, and delivers decoded pixels with their top-down
// row, column and a last-pixel flag. One input transfer is taken every clock
// cycle while in_stall is low; the pixel completed by a byte is registered in
// stage 1 with its palette read, then in the output register. Both sides are
// decoupled by that output register, so a byte can be taken while a finished
// pixel still waits downstream. Padding bytes, the first two bytes of a 24-bit
// pixel and palette writes give no output. The palette RAM has no reset and no
// clearing pass: entries must be written before an 8-bit palette image refers
// to them. Palette indices at or above PALETTE_DEPTH are dropped on write and
// read back as black. Geometry and mode registers are written over APB (width
// at 0x0, height at 0x4, mode at 0x8); the user must write them only while the
// decoder is idle; the block does not enforce it. A write clears no counter.
module bmp_pixel_array_decoder_core #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmpd_pkg::AddrW-1:0]  paddr,
  input  logic [bmpd_pkg::DataW-1:0]  pwdata,
  output logic [bmpd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [7:0]                  data_byte,
  input  logic [7:0]                  palette_index,
  input  logic [7:0]                  palette_red,
  input  logic [7:0]                  palette_green,
  input  logic [7:0]                  palette_blue,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [11:0]                 out_row,
  output logic [11:0]                 out_column,
  output logic                        last_pixel
);

  localparam int unsigned PalAw = $clog2(PALETTE_DEPTH);

  bmpd_pkg::bmpd_cfg_t cfg;
  bmpd_pkg::bmpd_pix_t pix;

  logic              in_accept;
  logic              pal_wr_en;
  logic              pal_rd_en;
  logic              pal_wr_hit;
  logic              pal_rd_hit;
  logic [23:0]       pal_rd_data;

  // stage 1: decoded pixel next to the palette read register
  logic              s1_valid;
  bmpd_pkg::bmpd_pix_t s1_pix;
  logic              s1_hit;
  logic              s1_advance;
  logic [7:0]        s1_red;
  logic [7:0]        s1_green;
  logic [7:0]        s1_blue;

  bmpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1 moves on when the output register is empty or being emptied;
  // input is held off only while both stages hold a pixel and output stalls.
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;

  bmpd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_accept),
    .operation (operation),
    .data_byte (data_byte),
    .cfg       (cfg),
    .pix       (pix)
  );

  // Palette: writes from palette transfers, reads for each palette-mode pixel
  assign pal_wr_hit = ({1'b0, palette_index} < 9'(PALETTE_DEPTH));
  assign pal_rd_hit = ({1'b0, data_byte} < 9'(PALETTE_DEPTH));
  assign pal_wr_en  = in_accept && (operation == bmpd_pkg::OP_PALETTE_WRITE)
                      && pal_wr_hit;
  assign pal_rd_en  = in_accept && pix.emit && pix.from_palette;

  bmpd_palette #(
    .Depth (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (palette_index[PalAw-1:0]),
    .wr_data ({palette_red, palette_green, palette_blue}),
    .rd_en   (pal_rd_en),
    .rd_addr (data_byte[PalAw-1:0]),
    .rd_data (pal_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= pix.emit;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix <= pix;
      s1_hit <= pal_rd_hit;
    end
  end

  // colour select: palette entry, black for an index past the palette,
  // or the components gathered by the sequencer
  always_comb begin
    if (s1_pix.from_palette) begin
      s1_red   = s1_hit ? pal_rd_data[23:16] : 8'd0;
      s1_green = s1_hit ? pal_rd_data[15:8]  : 8'd0;
      s1_blue  = s1_hit ? pal_rd_data[7:0]   : 8'd0;
    end else begin
      s1_red   = s1_pix.red;
      s1_green = s1_pix.green;
      s1_blue  = s1_pix.blue;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      red        <= s1_red;
      green      <= s1_green;
      blue       <= s1_blue;
      out_row    <= s1_pix.row;
      out_column <= s1_pix.column;
      last_pixel <= s1_pix.last;
    end
  end

endmodule
